// ===== rtl/plb_pkg.sv =====
`timescale 1ns / 1ps
// shared constants and types for the pose layer blend block
package plb_pkg;

   localparam int MAX_BONES_DEF = 128;

   // transaction modes, spare code behaves as a read
   typedef enum logic [1:0] {
      MODE_LOAD  = 2'd0,
      MODE_BLEND = 2'd1,
      MODE_READ  = 2'd2,
      MODE_SPARE = 2'd3
   } pose_mode_type;

   // one stored bone transform
   typedef struct packed {
      logic [31:0] pos_x;
      logic [31:0] pos_y;
      logic [15:0] angle;
      logic [31:0] scale_x;
      logic [31:0] scale_y;
   } pose_entry_type;

   localparam int ENTRY_W = $bits(pose_entry_type);

endpackage

// ===== rtl/plb_ram.sv =====
`timescale 1ns / 1ps
// generic single write port ram with registered read
module plb_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 2,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== rtl/pose_layer_blend.sv =====
`timescale 1ns / 1ps
// top level: per-bone pose store with layer blending through one shared multiplier
//
// A transaction is taken when start is high and busy is low; busy then stays high until
// the single result has been shown on the rsp_ ports for one cycle with rsp_valid high.
// The receiver cannot stall, so rsp_ fields must be captured in that cycle. Mode 0 loads
// a bone and modes 2 and 3 read it back: after the accepting edge the block passes through
// a fetch state and then the response state, and it takes the next transaction only once
// back in idle. Mode 1 blends the sample into the stored bone: after the fetch state it
// repeats the calc state over the components and then enters the response state. The five
// components pass one after another through a single 33 x 17 bit multiplier whose
// product is registered, and the rounding add of each component overlaps the next
// multiply. The pose store is one ram of MAX_BONES entries with a registered read, so every
// transaction passes through a fetch state. A bone index at or above MAX_BONES touches
// nothing and returns zeros. Store entries are undefined until loaded, with no clearing pass.
module pose_layer_blend #(
   parameter int MAX_BONES = plb_pkg::MAX_BONES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_mode,
   input  logic [6:0]         req_bone_index,
   input  logic [15:0]        req_weight,
   input  logic signed [31:0] req_src_pos_x,
   input  logic signed [31:0] req_src_pos_y,
   input  logic signed [15:0] req_src_angle,
   input  logic signed [31:0] req_src_scale_x,
   input  logic signed [31:0] req_src_scale_y,
   output logic               rsp_valid,
   output logic [6:0]         rsp_out_bone,
   output logic signed [31:0] rsp_out_pos_x,
   output logic signed [31:0] rsp_out_pos_y,
   output logic signed [15:0] rsp_out_angle,
   output logic signed [31:0] rsp_out_scale_x,
   output logic signed [31:0] rsp_out_scale_y
);

   import plb_pkg::*;

   localparam int AW = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;

   // component order through the multiplier
   localparam logic [2:0] COMP_POS_X   = 3'd0;
   localparam logic [2:0] COMP_POS_Y   = 3'd1;
   localparam logic [2:0] COMP_ANGLE   = 3'd2;
   localparam logic [2:0] COMP_SCALE_X = 3'd3;
   localparam logic [2:0] COMP_SCALE_Y = 3'd4;
   localparam logic [2:0] COMP_LAST    = 3'd5;

   localparam logic [15:0]       W_ONE   = 16'd32768;
   localparam logic signed [49:0] RND_HALF = 50'sd16384;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_CALC,
      ST_RESP
   } state_type;

   state_type        state_ff, state_in;
   logic [2:0]       cnt_ff, cnt_in;
   logic [1:0]       mode_ff, mode_in;
   logic [6:0]       bone_ff, bone_in;
   logic             hit_ff, hit_in;
   logic [15:0]      wgt_ff, wgt_in;
   pose_entry_type   src_ff, src_in;
   pose_entry_type   res_ff, res_in;
   logic signed [49:0] prod_ff, prod_in;

   // ram side
   pose_entry_type   ram_rd;
   logic [ENTRY_W-1:0] ram_rd_bits;
   logic             ram_we, ram_re;
   logic [31:0]      req_bone_ext, bone_ext;
   logic [AW-1:0]    ram_raddr, ram_waddr;

   // shared unit
   logic [31:0]        cur_m, src_m, cur_a, sum_a;
   logic [15:0]        dang;
   logic signed [32:0] diff_m;
   logic signed [49:0] shr_a;
   logic [2:0]         add_idx;

   function automatic logic [31:0] comp_of(input pose_entry_type e, input logic [2:0] k);
      logic [31:0] v;
      case (k)
         COMP_POS_X:   v = e.pos_x;
         COMP_POS_Y:   v = e.pos_y;
         COMP_ANGLE:   v = {16'd0, e.angle};
         COMP_SCALE_X: v = e.scale_x;
         COMP_SCALE_Y: v = e.scale_y;
         default:      v = 32'd0;
      endcase
      return v;
   endfunction

   assign req_bone_ext = 32'(req_bone_index);
   assign bone_ext     = 32'(bone_ff);
   assign ram_raddr    = req_bone_ext[AW-1:0];
   assign ram_waddr    = bone_ext[AW-1:0];
   assign ram_re       = start && (state_ff == ST_IDLE);
   // loads and blends commit from the result register in the response cycle
   assign ram_we       = (state_ff == ST_RESP) && hit_ff &&
                         ((mode_ff == MODE_LOAD) || (mode_ff == MODE_BLEND));
   assign ram_rd       = pose_entry_type'(ram_rd_bits);

   plb_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_BONES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (res_ff),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rd_bits)
   );

   // multiply stage: difference of component cnt, times weight, plus rounding half
   assign cur_m = comp_of(ram_rd, cnt_ff);
   assign src_m = comp_of(src_ff, cnt_ff);
   assign dang  = src_m[15:0] - cur_m[15:0];
   always_comb begin
      if (cnt_ff == COMP_ANGLE) begin
         // shortest arc: wrapped 16 bit difference
         diff_m = 33'(signed'(dang));
      end else begin
         diff_m = 33'(signed'(src_m)) - 33'(signed'(cur_m));
      end
   end

   // add stage: previous component, floor by arithmetic shift
   assign add_idx = cnt_ff - 3'd1;
   assign cur_a   = comp_of(ram_rd, add_idx);
   assign shr_a   = prod_ff >>> 15;
   assign sum_a   = cur_a + shr_a[31:0];

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      mode_in  = mode_ff;
      bone_in  = bone_ff;
      hit_in   = hit_ff;
      wgt_in   = wgt_ff;
      src_in   = src_ff;
      res_in   = res_ff;
      prod_in  = prod_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               mode_in        = req_mode;
               bone_in        = req_bone_index;
               hit_in         = req_bone_ext < 32'(MAX_BONES);
               wgt_in         = (req_weight > W_ONE) ? W_ONE : req_weight;
               src_in.pos_x   = req_src_pos_x;
               src_in.pos_y   = req_src_pos_y;
               src_in.angle   = req_src_angle;
               src_in.scale_x = req_src_scale_x;
               src_in.scale_y = req_src_scale_y;
               state_in       = ST_FETCH;
            end
         end
         ST_FETCH: begin
            cnt_in = COMP_POS_X;
            if (!hit_ff) begin
               res_in   = '0;
               state_in = ST_RESP;
            end else if (mode_ff == MODE_LOAD) begin
               res_in   = src_ff;
               state_in = ST_RESP;
            end else if (mode_ff == MODE_BLEND) begin
               state_in = ST_CALC;
            end else begin
               // read, unused mode 3 included
               res_in   = ram_rd;
               state_in = ST_RESP;
            end
         end
         ST_CALC: begin
            if (cnt_ff != COMP_LAST) begin
               prod_in = diff_m * $signed({1'b0, wgt_ff}) + RND_HALF;
            end
            if (cnt_ff != COMP_POS_X) begin
               case (add_idx)
                  COMP_POS_X:   res_in.pos_x   = sum_a;
                  COMP_POS_Y:   res_in.pos_y   = sum_a;
                  COMP_ANGLE:   res_in.angle   = sum_a[15:0];
                  COMP_SCALE_X: res_in.scale_x = sum_a;
                  default:      res_in.scale_y = sum_a;
               endcase
            end
            if (cnt_ff == COMP_LAST) begin
               state_in = ST_RESP;
            end else begin
               cnt_in = cnt_ff + 3'd1;
            end
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= COMP_POS_X;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      mode_ff <= mode_in;
      bone_ff <= bone_in;
      hit_ff  <= hit_in;
      wgt_ff  <= wgt_in;
      src_ff  <= src_in;
      res_ff  <= res_in;
      prod_ff <= prod_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = (state_ff == ST_RESP);
   assign rsp_out_bone    = bone_ff;
   assign rsp_out_pos_x   = res_ff.pos_x;
   assign rsp_out_pos_y   = res_ff.pos_y;
   assign rsp_out_angle   = res_ff.angle;
   assign rsp_out_scale_x = res_ff.scale_x;
   assign rsp_out_scale_y = res_ff.scale_y;

endmodule

// ===== rtl/plb_checker.sv =====
`timescale 1ns / 1ps
// port level checks for the pose layer blend block, bound to the top level
module plb_checker #(
   parameter int MAX_BONES = plb_pkg::MAX_BONES_DEF
) (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input logic [6:0]         rsp_out_bone,
   input logic signed [31:0] rsp_out_pos_x,
   input logic signed [31:0] rsp_out_pos_y,
   input logic signed [15:0] rsp_out_angle,
   input logic signed [31:0] rsp_out_scale_x,
   input logic signed [31:0] rsp_out_scale_y
);

   import plb_pkg::*;

   // an accepted transaction makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   // a result only shows while a transaction is open
   a_rsp_in_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe outside a transaction");

   // busy drops only right after the result
   a_busy_until_rsp: assert property (@(posedge clock) disable iff (reset)
      (busy && !rsp_valid) |=> busy)
      else $error("busy dropped without a result");

   // result closes the transaction
   a_rsp_closes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> (!busy && !rsp_valid))
      else $error("transaction still open after its result");

   // out of range bones return zeros
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (32'(rsp_out_bone) >= 32'(MAX_BONES))) |->
      ((rsp_out_pos_x == 32'sd0) && (rsp_out_pos_y == 32'sd0) &&
       (rsp_out_angle == 16'sd0) && (rsp_out_scale_x == 32'sd0) &&
       (rsp_out_scale_y == 32'sd0)))
      else $error("out of range bone returned nonzero transform");

endmodule

bind pose_layer_blend plb_checker #(.MAX_BONES(MAX_BONES)) u_plb_checker (.*);
